// ===== rtl/sirs_agent_interaction_assert.svh =====
// Assertion macros for the SIRS agent interaction block.
`ifndef SIRS_AGENT_INTERACTION_ASSERT_SVH
`define SIRS_AGENT_INTERACTION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks that prop holds at every rising clock edge outside reset.
`define SIA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIA_ASSERT(label, prop, msg)

`define SIA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/sia_pkg.sv =====
// Shared types, codes and constants of the SIRS agent interaction block.
`timescale 1ns / 1ps

package sia_pkg;

    localparam int AGENT_W  = 11;
    localparam int DRAW_W   = 16;
    localparam int PROB_W   = 17;
    localparam int HEALTH_W = 2;
    localparam int COUNT_W  = 12;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 3;

    localparam int POP_SIZE_DEF = 2048;

    localparam logic [PROB_W-1:0] BASE_INFECT_RST = 17'd3277;
    localparam logic [PROB_W-1:0] NOISE_RST       = 17'd9830;
    localparam logic [PROB_W-1:0] RECOVER_RST     = 17'd983;
    localparam logic [PROB_W-1:0] RETURN_RST      = 17'd1311;

    localparam logic [HEALTH_W-1:0] HEALTH_SUSC = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_INF  = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_REC  = 2'd2;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_BASE_INFECT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NOISE       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RECOVER     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RETURN      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIR_ONLY    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RING_MODE   = 3'd5;

    typedef struct packed {
        logic                op;
        logic [AGENT_W-1:0]  agent;
        logic [AGENT_W-1:0]  partner;
        logic                go_left;
        logic [DRAW_W-1:0]   noise_draw;
        logic [DRAW_W-1:0]   infect_draw;
        logic [DRAW_W-1:0]   recover_draw;
        logic [DRAW_W-1:0]   return_draw;
        logic [HEALTH_W-1:0] load_state;
    } t_in_item;

    typedef struct packed {
        logic                accepted;
        logic [HEALTH_W-1:0] agent_state;
        logic [HEALTH_W-1:0] partner_state;
        logic [COUNT_W-1:0]  susceptible_count;
        logic [COUNT_W-1:0]  infected_count;
        logic [COUNT_W-1:0]  recovered_count;
    } t_out_item;

    typedef struct packed {
        logic [PROB_W-1:0] base_infect_prob;
        logic [PROB_W-1:0] noise_prob;
        logic [PROB_W-1:0] recover_prob;
        logic [PROB_W-1:0] return_prob;
        logic              sir_only;
        logic              ring_mode;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic clear_wr;
        logic rd;
        logic wr_agent;
        logic wr_partner;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic item_ok;
        logic is_load;
    } t_dp_status;

endpackage

// ===== rtl/sia_regs.sv =====
// APB configuration registers of the SIRS agent interaction block.
`timescale 1ns / 1ps

module sia_regs import sia_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_infect_prob <= BASE_INFECT_RST;
            r_cfg.noise_prob       <= NOISE_RST;
            r_cfg.recover_prob     <= RECOVER_RST;
            r_cfg.return_prob      <= RETURN_RST;
            r_cfg.sir_only         <= 1'b0;
            r_cfg.ring_mode        <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_BASE_INFECT: r_cfg.base_infect_prob <= pwdata[PROB_W-1:0];
                REG_NOISE:       r_cfg.noise_prob       <= pwdata[PROB_W-1:0];
                REG_RECOVER:     r_cfg.recover_prob     <= pwdata[PROB_W-1:0];
                REG_RETURN:      r_cfg.return_prob      <= pwdata[PROB_W-1:0];
                REG_SIR_ONLY:    r_cfg.sir_only         <= pwdata[0];
                REG_RING_MODE:   r_cfg.ring_mode        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASE_INFECT: prdata = APB_DW'(r_cfg.base_infect_prob);
            REG_NOISE:       prdata = APB_DW'(r_cfg.noise_prob);
            REG_RECOVER:     prdata = APB_DW'(r_cfg.recover_prob);
            REG_RETURN:      prdata = APB_DW'(r_cfg.return_prob);
            REG_SIR_ONLY:    prdata = APB_DW'(r_cfg.sir_only);
            REG_RING_MODE:   prdata = APB_DW'(r_cfg.ring_mode);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/sia_datapath.sv =====
// Datapath: population store, class counters, partner selection and state update.
`timescale 1ns / 1ps

module sia_datapath import sia_pkg::*; #(
    parameter int POP_SIZE = POP_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_out
);

    localparam int IDX_W = $clog2(POP_SIZE);
    localparam int EXT_W = ((IDX_W > AGENT_W) ? IDX_W : AGENT_W) + 1;
    localparam logic [EXT_W-1:0]   POP_EXT  = EXT_W'(POP_SIZE);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(POP_SIZE - 1);
    localparam logic [COUNT_W-1:0] POP_CNT  = COUNT_W'(POP_SIZE);

    t_in_item            r_item;
    t_out_item           r_out;
    logic [HEALTH_W-1:0] r_mem [POP_SIZE];
    logic [HEALTH_W-1:0] r_rd_agent;
    logic [HEALTH_W-1:0] r_rd_partner;
    logic [HEALTH_W-1:0] r_a_new;
    logic [HEALTH_W-1:0] r_p_new;
    logic [IDX_W-1:0]    r_clr_addr;
    logic [COUNT_W-1:0]  r_cnt [3];
    logic [COUNT_W-1:0]  n_cnt [3];

    logic [EXT_W-1:0]    agent_ext;
    logic [EXT_W-1:0]    partner_ext;
    logic [IDX_W-1:0]    agent_idx;
    logic [IDX_W-1:0]    left_idx;
    logic [IDX_W-1:0]    right_idx;
    logic [IDX_W-1:0]    partner_idx;
    logic                is_load;
    logic                item_ok;
    logic                noise_hit;
    logic                infect_hit;
    logic                recover_hit;
    logic                return_hit;
    logic [HEALTH_W-1:0] a1;
    logic [HEALTH_W-1:0] a2;
    logic [HEALTH_W-1:0] a3;
    logic [HEALTH_W-1:0] p1;
    logic [HEALTH_W-1:0] agent_new;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [HEALTH_W-1:0] wr_data;
    logic [HEALTH_W-1:0] upd_old;
    logic [HEALTH_W-1:0] upd_new;

    // Partner choice and validity of the held request.
    assign agent_ext   = EXT_W'(r_item.agent);
    assign partner_ext = EXT_W'(r_item.partner);
    assign agent_idx   = agent_ext[IDX_W-1:0];
    assign left_idx    = (agent_idx == '0) ? LAST_IDX : agent_idx - IDX_W'(1);
    assign right_idx   = (agent_idx == LAST_IDX) ? '0 : agent_idx + IDX_W'(1);
    assign partner_idx = i_cfg.ring_mode ? (r_item.go_left ? left_idx : right_idx)
                                         : partner_ext[IDX_W-1:0];
    assign is_load     = (r_item.op == OP_LOAD);

    always_comb begin
        if (agent_ext >= POP_EXT) begin
            item_ok = 1'b0;
        end else if (is_load) begin
            item_ok = (r_item.load_state == HEALTH_SUSC) || (r_item.load_state == HEALTH_INF)
                   || (r_item.load_state == HEALTH_REC);
        end else begin
            item_ok = i_cfg.ring_mode
                   || ((partner_ext < POP_EXT) && (r_item.partner != r_item.agent));
        end
    end

    // A noise hit makes the infection certain, whatever the base probability.
    assign noise_hit   = PROB_W'(r_item.noise_draw) < i_cfg.noise_prob;
    assign infect_hit  = noise_hit || (PROB_W'(r_item.infect_draw) < i_cfg.base_infect_prob);
    assign recover_hit = PROB_W'(r_item.recover_draw) < i_cfg.recover_prob;
    assign return_hit  = PROB_W'(r_item.return_draw) < i_cfg.return_prob;

    // The agent passes through infection, spreading, recovery and return in that order.
    assign a1 = (r_rd_agent == HEALTH_SUSC && r_rd_partner == HEALTH_INF && infect_hit)
              ? HEALTH_INF : r_rd_agent;
    assign p1 = (a1 == HEALTH_INF && r_rd_partner == HEALTH_SUSC && infect_hit)
              ? HEALTH_INF : r_rd_partner;
    assign a2 = (a1 == HEALTH_INF && recover_hit) ? HEALTH_REC : a1;
    assign a3 = (a2 == HEALTH_REC && !i_cfg.sir_only && return_hit) ? HEALTH_SUSC : a2;
    assign agent_new = is_load ? r_item.load_state : a3;

    // One write port: clearing pass, then agent, then partner.
    always_comb begin
        wr_en   = i_cmd.clear_wr || i_cmd.wr_agent || i_cmd.wr_partner;
        wr_addr = r_clr_addr;
        wr_data = HEALTH_SUSC;
        if (i_cmd.wr_agent) begin
            wr_addr = agent_idx;
            wr_data = agent_new;
        end else if (i_cmd.wr_partner) begin
            wr_addr = partner_idx;
            wr_data = r_p_new;
        end
    end

    // Each agent or partner write that changes a state moves one agent between class counters.
    always_comb begin
        n_cnt   = r_cnt;
        upd_old = r_rd_agent;
        upd_new = agent_new;
        if (i_cmd.wr_partner) begin
            upd_old = r_rd_partner;
            upd_new = r_p_new;
        end
        if ((i_cmd.wr_agent || i_cmd.wr_partner) && (upd_old != upd_new)) begin
            n_cnt[upd_old] = n_cnt[upd_old] - COUNT_W'(1);
            n_cnt[upd_new] = n_cnt[upd_new] + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_agent   <= r_mem[agent_idx];
            r_rd_partner <= r_mem[partner_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr         <= '0;
            r_cnt[HEALTH_SUSC] <= POP_CNT;
            r_cnt[HEALTH_INF]  <= '0;
            r_cnt[HEALTH_REC]  <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.wr_agent) begin
            r_a_new <= agent_new;
            r_p_new <= is_load ? HEALTH_SUSC : p1;
        end
        if (i_cmd.out_load) begin
            r_out.accepted          <= item_ok;
            r_out.agent_state       <= item_ok ? r_a_new : HEALTH_SUSC;
            r_out.partner_state     <= item_ok ? r_p_new : HEALTH_SUSC;
            r_out.susceptible_count <= r_cnt[HEALTH_SUSC];
            r_out.infected_count    <= r_cnt[HEALTH_INF];
            r_out.recovered_count   <= r_cnt[HEALTH_REC];
        end
    end

    assign o_status.clear_last = (r_clr_addr == LAST_IDX);
    assign o_status.item_ok    = item_ok;
    assign o_status.is_load    = is_load;
    assign o_out               = r_out;

endmodule

// ===== rtl/sia_ctrl.sv =====
// Controller state machine: clearing pass and per-request store sequence.
`timescale 1ns / 1ps

module sia_ctrl import sia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PART,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = i_status.item_ok ? ST_EVAL : ST_DONE;
            end
            ST_EVAL: begin
                o_cmd.wr_agent = 1'b1;
                n_state        = i_status.is_load ? ST_DONE : ST_PART;
            end
            ST_PART: begin
                o_cmd.wr_partner = 1'b1;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                // Wait here until the output register is free or being emptied.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/sirs_agent_interaction.sv =====
// Top level of the SIRS agent interaction block: registers, controller and datapath.
// Interaction: states IDLE, READ, EVAL, PART, then DONE, where the result register loads.
// Load skips PART; a rejected request goes from READ to DONE. A new request waits for IDLE.
// The single write port of the population store writes agent and partner in turn.
// Reset is synchronous; a clearing pass over all POP_SIZE entries follows, with no request taken.
`timescale 1ns / 1ps
`include "sirs_agent_interaction_assert.svh"

module sirs_agent_interaction import sia_pkg::*; #(
    parameter int POP_SIZE = POP_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sia_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    sia_datapath #(
        .POP_SIZE (POP_SIZE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_in_data),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_out    (o_out_data)
    );

    `SIA_ASSERT(a_count_total, o_out_valid |-> ((o_out_data.susceptible_count + o_out_data.infected_count + o_out_data.recovered_count) == COUNT_W'(POP_SIZE)), "class counts do not add up to the population")
    `SIA_ASSERT(a_reject_zero, (o_out_valid && !o_out_data.accepted) |-> ((o_out_data.agent_state == HEALTH_SUSC) && (o_out_data.partner_state == HEALTH_SUSC)), "rejected request reports nonzero states")
    `SIA_ASSERT(a_one_write, $onehot0({dp_cmd.clear_wr, dp_cmd.wr_agent, dp_cmd.wr_partner}), "more than one store write in a cycle")
    `SIA_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "second request taken while one is in progress")

endmodule
